>>> src/flash_erase_range_planner_defines.svh
// Assertion macros used by the planner core (fer_core).
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef FLASH_ERASE_RANGE_PLANNER_DEFINES_SVH
`define FLASH_ERASE_RANGE_PLANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FER_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define FER_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/fer_pkg.sv
package fer_pkg;

   // fixed field widths of the request and response words
   localparam int ADDR_W = 24;
   localparam int LEN_W  = 25;

   // request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DONE  = 1'b1;

   // erase opcodes
   localparam logic [7:0] OP_NONE   = 8'h00;
   localparam logic [7:0] OP_SECTOR = 8'h20;
   localparam logic [7:0] OP_BLOCK  = 8'hD8;

   // response status codes
   localparam logic [2:0] ST_ISSUED     = 3'd0;
   localparam logic [2:0] ST_DONE       = 3'd1;
   localparam logic [2:0] ST_MISALIGNED = 3'd2;
   localparam logic [2:0] ST_ABORTED    = 3'd3;
   localparam logic [2:0] ST_REJECTED   = 3'd4;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] start_address;
      logic [LEN_W-1:0]  length;
      logic              failed;
   } fer_req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [7:0]        opcode;
      logic [ADDR_W-1:0] command_address;
      logic              last;
   } fer_rsp_type;

endpackage

>>> src/flash_erase_range_planner.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   func, start_address, length, failed
// rsp       out        rsp_valid/rsp_stall   status, opcode, command_address, last
//
// One word per cycle sustained while rsp_stall is low; each request word gives one
// response word (input register, then decode into the result register).
// The planner state is updated as a word enters the result register, so the next
// word sees it at once.
// Reset is synchronous and active high; it clears the state to idle.
// rsp_stall holds a full result register and, once the input register is full too, req.
module flash_erase_range_planner import fer_pkg::*; #(
   parameter int SECTOR_BYTES = 4096,
   parameter int BLOCK_BYTES  = 65536,
   parameter int ADDR_BITS    = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_start_address,
   input  logic [LEN_W-1:0]  req_length,
   input  logic              req_failed,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_opcode,
   output logic [ADDR_W-1:0] rsp_command_address,
   output logic              rsp_last
);

   fer_req_type req_word, stage_word;
   fer_rsp_type res_word, rsp_word;
   logic        stage_valid, stage_take, out_ready;

   always_comb begin
      req_word.func          = req_func;
      req_word.start_address = req_start_address;
      req_word.length        = req_length;
      req_word.failed        = req_failed;
   end

   fer_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .stage_take  (stage_take)
   );

   fer_core #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .out_ready   (out_ready),
      .stage_take  (stage_take),
      .res_word    (res_word)
   );

   fer_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (stage_valid),
      .res_word  (res_word),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_status          = rsp_word.status;
   assign rsp_opcode          = rsp_word.opcode;
   assign rsp_command_address = rsp_word.command_address;
   assign rsp_last            = rsp_word.last;

endmodule

>>> src/fer_in_reg.sv
module fer_in_reg import fer_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fer_req_type req_word,
   output logic        stage_valid,
   output fer_req_type stage_word,
   input  logic        stage_take
);

   logic        valid_ff, valid_in;
   fer_req_type word_ff;
   logic        load;

   // hold a word until the core consumes it
   assign req_stall = valid_ff && !stage_take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

>>> src/fer_core.sv
`include "flash_erase_range_planner_defines.svh"

module fer_core import fer_pkg::*; #(
   parameter int SECTOR_BYTES = 4096,
   parameter int BLOCK_BYTES  = 65536,
   parameter int ADDR_BITS    = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        stage_valid,
   input  fer_req_type stage_word,
   input  logic        out_ready,
   output logic        stage_take,
   output fer_rsp_type res_word
);

   // internal width covers start + length and one block past the top
   localparam int AW = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int NW = AW + 2;

   localparam logic [NW-1:0] SEC_W    = NW'(SECTOR_BYTES);
   localparam logic [NW-1:0] BLK_W    = NW'(BLOCK_BYTES);
   localparam logic [NW-1:0] SEC_MASK = SEC_W - NW'(1);
   localparam logic [NW-1:0] BLK_MASK = BLK_W - NW'(1);
   localparam logic [NW-1:0] TOP_W    = (NW'(1) << ADDR_BITS) - NW'(1);

   logic                 active_ff, active_in;
   logic [NW-1:0]        next_address_ff, next_address_in;
   logic [ADDR_BITS-1:0] final_sector_ff, final_sector_in;

   logic [NW-1:0] start_w, len_w, end_w, clip_w, fs_start;
   logic [NW-1:0] a_w, fs_w, nxt_w;
   logic          misaligned, is_start, blk, last_cmd;
   fer_rsp_type   issue_word;

   assign stage_take = stage_valid && out_ready;
   assign is_start   = (stage_word.func == FUNC_START);

   // range of a new request: last sector start, clipped to the address space
   assign start_w    = NW'(stage_word.start_address) & TOP_W;
   assign len_w      = NW'(stage_word.length);
   assign end_w      = start_w + len_w - NW'(1);
   assign clip_w     = (end_w > TOP_W) ? TOP_W : end_w;
   assign fs_start   = clip_w & ~SEC_MASK;
   assign misaligned = (start_w & SEC_MASK) != NW'(0);

   // command selection at the current address
   assign a_w      = is_start ? start_w : next_address_ff;
   assign fs_w     = is_start ? fs_start : NW'(final_sector_ff);
   assign blk      = ((a_w & BLK_MASK) == NW'(0)) && (fs_w >= a_w) &&
                     ((fs_w - a_w) >= BLK_W);
   assign nxt_w    = a_w + (blk ? BLK_W : SEC_W);
   assign last_cmd = nxt_w > fs_w;

   always_comb begin
      issue_word.status          = ST_ISSUED;
      issue_word.opcode          = blk ? OP_BLOCK : OP_SECTOR;
      issue_word.command_address = a_w[ADDR_W-1:0];
      issue_word.last            = last_cmd;
   end

   // event decode and next state
   always_comb begin
      res_word        = '0;
      res_word.status = ST_REJECTED;
      res_word.opcode = OP_NONE;
      active_in       = active_ff;
      next_address_in = next_address_ff;
      final_sector_in = final_sector_ff;
      if (is_start) begin
         if (active_ff) begin
            res_word.status = ST_REJECTED;
         end else if (misaligned) begin
            res_word.status = ST_MISALIGNED;
         end else if (stage_word.length == '0) begin
            res_word.status = ST_DONE;
         end else begin
            res_word        = issue_word;
            active_in       = 1'b1;
            next_address_in = nxt_w;
            final_sector_in = fs_start[ADDR_BITS-1:0];
         end
      end else begin
         if (!active_ff) begin
            res_word.status = ST_REJECTED;
         end else if (stage_word.failed) begin
            res_word.status = ST_ABORTED;
            active_in       = 1'b0;
         end else if (next_address_ff > NW'(final_sector_ff)) begin
            res_word.status = ST_DONE;
            active_in       = 1'b0;
         end else begin
            res_word        = issue_word;
            next_address_in = nxt_w;
         end
      end
   end

   // planner state advances only when the word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         next_address_ff <= '0;
         final_sector_ff <= '0;
      end else if (stage_take) begin
         active_ff       <= active_in;
         next_address_ff <= next_address_in;
         final_sector_ff <= final_sector_in;
      end
   end

   `FER_ASSERT_NEXT(issue_advances_a, stage_take && res_word.status == ST_ISSUED, active_ff && (next_address_ff > $past(a_w)), "issued command did not advance the plan")
   `FER_ASSERT_NEXT(end_goes_idle_a, stage_take && (res_word.status == ST_ABORTED || res_word.status == ST_DONE), !active_ff, "planner still active after finish or abort")
   `FER_ASSERT_NEXT(reject_keeps_a, stage_take && res_word.status == ST_REJECTED, $stable(active_ff) && $stable(next_address_ff) && $stable(final_sector_ff), "rejected word changed planner state")

endmodule

>>> src/fer_out_reg.sv
module fer_out_reg import fer_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        res_valid,
   input  fer_rsp_type res_word,
   output logic        out_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fer_rsp_type rsp_word
);

   logic        valid_ff, valid_in;
   fer_rsp_type word_ff;
   logic        load;

   // room when empty or when the held word leaves this cycle
   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = res_valid && out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= res_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

>>> tb/erase_plan_checker.sv
`timescale 1ns / 1ps

module erase_plan_checker import fer_pkg::*; #(
   parameter int SECTOR_BYTES = 4096,
   parameter int BLOCK_BYTES  = 65536,
   parameter int ADDR_BITS    = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_start_address,
   input  logic [LEN_W-1:0]  req_length,
   input  logic              req_failed,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [2:0]        rsp_status,
   input  logic [7:0]        rsp_opcode,
   input  logic [ADDR_W-1:0] rsp_command_address,
   input  logic              rsp_last,
   output int                mismatches,
   output int                outstanding
);

   // two spare bits so that range ends and the advanced address never wrap
   localparam logic [ADDR_W+1:0] ADDR_TOP = (26'd1 << ADDR_BITS) - 26'd1;

   // planner state as seen by the prediction
   logic              run_busy;
   logic [ADDR_W+1:0] erase_ptr;
   logic [ADDR_W+1:0] final_sector_base;

   fer_rsp_type expected_rsp_q[$];

   task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
      $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
      mismatches++;
   endtask

   // next erase command at the current pointer; a block only when the range runs a full
   // block past a block-aligned pointer
   task automatic plan_erase_command(output fer_rsp_type r);
      logic [ADDR_W+1:0] a;
      a = erase_ptr;
      if (a % BLOCK_BYTES == 0 && final_sector_base >= a &&
          final_sector_base - a >= BLOCK_BYTES) begin
         r.opcode  = OP_BLOCK;
         erase_ptr = a + 26'(BLOCK_BYTES);
      end else begin
         r.opcode  = OP_SECTOR;
         erase_ptr = a + 26'(SECTOR_BYTES);
      end
      r.status          = ST_ISSUED;
      r.command_address = a[ADDR_W-1:0];
      r.last            = erase_ptr > final_sector_base;
   endtask

   task automatic plan_request(input logic func, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] len, input logic failed);
      fer_rsp_type       r;
      logic [ADDR_W+1:0] base;
      logic [ADDR_W+1:0] last_byte;
      r.status          = ST_REJECTED;
      r.opcode          = OP_NONE;
      r.command_address = '0;
      r.last            = 1'b0;
      base = 26'(addr) & ADDR_TOP;
      if (func == FUNC_START) begin
         if (run_busy) begin
            r.status = ST_REJECTED;
         end else if (base % SECTOR_BYTES != 0) begin
            r.status = ST_MISALIGNED;
         end else if (len == 0) begin
            r.status = ST_DONE;
         end else begin
            // clip the range at the top of the address space
            last_byte = base + 26'(len) - 26'd1;
            if (last_byte > ADDR_TOP) last_byte = ADDR_TOP;
            final_sector_base = last_byte - 26'(last_byte % SECTOR_BYTES);
            erase_ptr         = base;
            run_busy          = 1'b1;
            plan_erase_command(r);
         end
      end else if (run_busy) begin
         if (failed) begin
            run_busy = 1'b0;
            r.status = ST_ABORTED;
         end else if (erase_ptr > final_sector_base) begin
            run_busy = 1'b0;
            r.status = ST_DONE;
         end else begin
            plan_erase_command(r);
         end
      end
      expected_rsp_q.push_back(r);
   endtask

   // responses are checked before the request of the same edge is planned
   always @(posedge clock) begin
      fer_rsp_type e;
      if (reset) begin
         run_busy          = 1'b0;
         erase_ptr         = '0;
         final_sector_base = '0;
         mismatches        = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               note_mismatch("response word with none pending", 0, rsp_status);
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_status !== e.status) note_mismatch("status", e.status, rsp_status);
               if (rsp_opcode !== e.opcode) note_mismatch("opcode", e.opcode, rsp_opcode);
               if (rsp_command_address !== e.command_address)
                  note_mismatch("command_address", e.command_address, rsp_command_address);
               if (rsp_last !== e.last) note_mismatch("last", e.last, rsp_last);
            end
         end
         if (req_valid && !req_stall)
            plan_request(req_func, req_start_address, req_length, req_failed);
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb import fer_pkg::*; ();

   localparam int SECTOR_BYTES = 4096;
   localparam int BLOCK_BYTES  = 65536;
   localparam int ADDR_BITS    = 24;
   localparam int RANDOM_WORDS = 650;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_func;
   logic [ADDR_W-1:0] req_start_address;
   logic [LEN_W-1:0]  req_length;
   logic              req_failed;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [2:0]        rsp_status;
   logic [7:0]        rsp_opcode;
   logic [ADDR_W-1:0] rsp_command_address;
   logic              rsp_last;

   int mismatches;
   int outstanding;
   int words_sent = 0;
   bit gaps_on = 1'b1;
   bit long_hold_req = 1'b0;

   flash_erase_range_planner #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_start_address  (req_start_address),
      .req_length         (req_length),
      .req_failed         (req_failed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_opcode         (rsp_opcode),
      .rsp_command_address(rsp_command_address),
      .rsp_last           (rsp_last)
   );

   erase_plan_checker #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_start_address  (req_start_address),
      .req_length         (req_length),
      .req_failed         (req_failed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_opcode         (rsp_opcode),
      .rsp_command_address(rsp_command_address),
      .rsp_last           (rsp_last),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      #(12 * 300000);
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
         end
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < 22);
      end
   end

   // offer one request word and hold it until it is taken
   task automatic send_word(input logic func, input logic [ADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] len, input logic failed);
      while (gaps_on && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_start_address <= addr;
      req_length        <= len;
      req_failed        <= failed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // sender goes quiet until every response has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [ADDR_W-1:0] any_addr();
      return ADDR_W'($urandom_range(0, 24'hFFFFFF));
   endfunction

   function automatic logic [LEN_W-1:0] any_len();
      return LEN_W'($urandom_range(0, 25'h1000000));
   endfunction

   // number of erase commands a range takes; used only to size completion runs
   function automatic int erase_cmd_count(input logic [ADDR_W-1:0] base,
                                          input logic [LEN_W-1:0] len);
      logic [ADDR_W+1:0] last_byte;
      logic [ADDR_W+1:0] fin;
      logic [ADDR_W+1:0] a;
      int n;
      n = 0;
      if (len == 0) return 0;
      last_byte = 26'(base) + 26'(len) - 26'd1;
      if (last_byte > 26'hFFFFFF) last_byte = 26'hFFFFFF;
      fin = last_byte - 26'(last_byte % SECTOR_BYTES);
      a = 26'(base);
      while (a <= fin) begin
         if (a % BLOCK_BYTES == 0 && fin - a >= BLOCK_BYTES) a = a + 26'(BLOCK_BYTES);
         else a = a + 26'(SECTOR_BYTES);
         n++;
      end
      return n;
   endfunction

   // one start word followed by its completions, sometimes with one extra, sometimes cut short by a failure
   task automatic erase_run();
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  len;
      int pick;
      int n;
      int cut;
      pick = $urandom_range(0, 99);
      if (pick < 50)      base = {8'($urandom_range(0, 255)), 16'h0};
      else if (pick < 85) base = {12'($urandom_range(0, 4095)), 12'h0};
      else                base = {12'($urandom_range(4032, 4095)), 12'h0};
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = LEN_W'($urandom_range(1, 25'h30000));
      else if (pick < 85) len = LEN_W'($urandom_range(1, 40) * SECTOR_BYTES);
      else if (pick < 95) len = LEN_W'($urandom_range(25'h100000, 25'h1000000));
      else                len = '0;
      send_word(FUNC_START, base, len, 1'b0);
      n = erase_cmd_count(base, len);
      if (n == 0) return;
      if ($urandom_range(0, 9) == 0) n++;
      cut = 0;
      if (n > 40) cut = $urandom_range(1, 30);
      else if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, n);
      for (int i = 1; i <= n; i++) begin
         if (i == cut) begin
            send_word(FUNC_DONE, any_addr(), any_len(), 1'b1);
            break;
         end
         send_word(FUNC_DONE, any_addr(), any_len(), 1'b0);
      end
   endtask

   initial begin
      bit hold_done;
      bit drained;
      hold_done = 1'b0;
      drained   = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_func          <= FUNC_START;
      req_start_address <= '0;
      req_length        <= '0;
      req_failed        <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // completions while idle
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      send_word(FUNC_DONE, 24'hFFFFFF, 25'h0FFFFFF, 1'b1);
      // misaligned starts, the alignment test ahead of the zero-length test
      send_word(FUNC_START, 24'hFFFFFF, 25'h1000000, 1'b0);
      send_word(FUNC_START, 24'h000800, 25'h0000000, 1'b0);
      // zero length finishes at once
      send_word(FUNC_START, 24'h005000, 25'h0000000, 1'b0);
      // one byte, start while busy, abort, then a completion with nothing running
      send_word(FUNC_START, 24'h000000, 25'h0000001, 1'b0);
      send_word(FUNC_START, 24'h123000, 25'h0000005, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b1);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      // block then sector, finish, stray completion
      send_word(FUNC_START, 24'h010000, 25'h0011000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      // ranges clipped at the top of the address space
      send_word(FUNC_START, 24'hFFF000, 25'h1000000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      send_word(FUNC_START, 24'hFE0000, 25'h0FFFFFF, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b1);
      // whole device, aborted after the first block
      send_word(FUNC_START, 24'h000000, 25'h1000000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b1);
      // failure reported on the last completion
      send_word(FUNC_START, 24'h003000, 25'h0002000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b0);
      send_word(FUNC_DONE, 24'h000000, 25'h0000000, 1'b1);
      wait_drain();

      // random runs mixed with noise words
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         if (!hold_done && words_sent >= 200) begin
            hold_done     = 1'b1;
            long_hold_req = 1'b1;
         end
         gaps_on = !(words_sent >= 300 && words_sent < 430);
         if (!drained && words_sent >= 460) begin
            drained = 1'b1;
            wait_drain();
         end
         if ($urandom_range(0, 99) < 15)
            send_word(1'($urandom_range(0, 1)), any_addr(), any_len(),
                      1'($urandom_range(0, 1)));
         else
            erase_run();
      end
      gaps_on = 1'b1;
      wait_drain();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
